// ===== hw/rtl/brbi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brbi_pkg;

	localparam int DEPTH = 1024;
	localparam int POS_W = 10;
	localparam int CNT_W = 11;
	localparam int REQ_W = 3;
	localparam int DAT_W = 8;

	localparam logic [REQ_W-1:0] REQ_APPEND      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ_AT     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLAIM       = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CONSUME     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TAIL_SPACE  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_ADVANCE     = 3'd5;
	localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd6;
	localparam logic [REQ_W-1:0] REQ_WRITE_AHEAD = 3'd7;

	typedef struct packed {
		logic load;
		logic exec;
		logic cfg_wr;
	} brbi_cmd_t;

	// p < sz and n <= sz, so one conditional subtract wraps the sum
	function automatic logic [POS_W-1:0] ring_add(input logic [POS_W-1:0] p,
			input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] sz);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
		if (s >= (CNT_W+1)'(sz)) begin
			s = s - (CNT_W+1)'(sz);
		end
		return s[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/byte_ring_buffer_inflight_top.sv =====
// Byte ring buffer with claim/consume tracking.
// Requests: pulse start with req_type, data_byte and amount while busy is
// low; the request is taken at that edge. busy is high for the one cycle
// in which the request executes (store access plus pointer/count update).
// The result beat follows in the next cycle: done is high for exactly one
// cycle and the result ports are valid only then. A new request may be
// started in that same cycle; none is taken while one executes. The
// read of the 1024-byte store is registered.
// The result receiver cannot stall; it must take each beat as it comes.
// buf_size is written over cfg_valid/cfg_ready (ready while not busy);
// a write also empties the ring. Counts in each result reflect the state
// after the request.
// Reset (arst_n low) empties the ring and sets buf_size to 1024. Store
// contents are not cleared; bytes only become readable once held.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_inflight_top import brbi_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [REQ_W-1:0] req_type,
	input  wire logic [DAT_W-1:0] data_byte,
	input  wire logic [CNT_W-1:0] amount,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data,
	output logic                  done,
	output logic      [DAT_W-1:0] read_byte,
	output logic      [POS_W-1:0] chunk_pos,
	output logic      [CNT_W-1:0] chunk_len,
	output logic      [CNT_W-1:0] used_count,
	output logic      [CNT_W-1:0] free_count,
	output logic      [CNT_W-1:0] inflight_count,
	output logic                  error
);

	brbi_cmd_t cmd;

	brbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done),
		.cmd       (cmd)
	);

	brbi_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.data_byte      (data_byte),
		.amount         (amount),
		.cfg_data       (cfg_data),
		.read_byte      (read_byte),
		.chunk_pos      (chunk_pos),
		.chunk_len      (chunk_len),
		.used_count     (used_count),
		.free_count     (free_count),
		.inflight_count (inflight_count),
		.error          (error)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/brbi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brbi_ctrl import brbi_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire logic  cfg_valid,
	output logic       busy,
	output logic       cfg_ready,
	output logic       done,
	output brbi_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy      = (state_q == ST_EXEC);
	assign cfg_ready = !busy;
	assign done      = (state_q == ST_DONE);

	assign cmd.load   = start && !busy;
	assign cmd.exec   = busy;
	assign cmd.cfg_wr = cfg_valid && cfg_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// result beat goes out while the next request is taken
				state_d = start ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/brbi_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brbi_datapath import brbi_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire brbi_cmd_t        cmd,
	input  wire logic [REQ_W-1:0] req_type,
	input  wire logic [DAT_W-1:0] data_byte,
	input  wire logic [CNT_W-1:0] amount,
	input  wire logic [CNT_W-1:0] cfg_data,
	output logic      [DAT_W-1:0] read_byte,
	output logic      [POS_W-1:0] chunk_pos,
	output logic      [CNT_W-1:0] chunk_len,
	output logic      [CNT_W-1:0] used_count,
	output logic      [CNT_W-1:0] free_count,
	output logic      [CNT_W-1:0] inflight_count,
	output logic                  error
);

	logic [DAT_W-1:0] mem [DEPTH];

	logic [REQ_W-1:0] req_q;
	logic [DAT_W-1:0] data_q;
	logic [CNT_W-1:0] amount_q;

	logic [CNT_W-1:0] buf_size_q;
	logic [POS_W-1:0] head_q;
	logic [POS_W-1:0] tail_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] claimed_q;

	logic [DAT_W-1:0] rdata_q;
	logic             rd_ok_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] len_q;
	logic             err_q;

	logic [CNT_W-1:0] sz;
	logic [CNT_W-1:0] space;
	logic [POS_W-1:0] head_adv;
	logic [POS_W-1:0] claim_pos;
	logic [POS_W-1:0] tail_adv;
	logic [CNT_W-1:0] tail_n;
	logic [POS_W-1:0] mem_addr;
	logic [CNT_W-1:0] avail;
	logic [CNT_W-1:0] room;
	logic [CNT_W-1:0] claim_len;

	logic [POS_W-1:0] head_d;
	logic [POS_W-1:0] tail_d;
	logic [CNT_W-1:0] used_d;
	logic [CNT_W-1:0] claimed_d;
	logic [POS_W-1:0] pos_d;
	logic [CNT_W-1:0] len_d;
	logic             err_d;
	logic             wr_en;
	logic             rd_ok;

	always_comb begin
		if (buf_size_q == '0) begin
			sz = CNT_W'(1);
		end else if (buf_size_q > CNT_W'(DEPTH)) begin
			sz = CNT_W'(DEPTH);
		end else begin
			sz = buf_size_q;
		end
	end

	assign space     = sz - used_q;
	assign head_adv  = ring_add(head_q, amount_q, sz);
	assign claim_pos = ring_add(head_q, claimed_q, sz);
	assign tail_n    = (req_q == REQ_APPEND) ? CNT_W'(1) : amount_q;
	assign tail_adv  = ring_add(tail_q, tail_n, sz);
	// append writes at tail itself, write-ahead at an offset from it
	assign mem_addr  = (req_q == REQ_READ_AT) ? head_adv :
	                   (req_q == REQ_WRITE_AHEAD) ? tail_adv : tail_q;

	assign avail = used_q - claimed_q;
	assign room  = sz - CNT_W'(claim_pos);

	always_comb begin
		claim_len = avail;
		if (claim_len > room) claim_len = room;
		if (claim_len > amount_q) claim_len = amount_q;
	end

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		used_d    = used_q;
		claimed_d = claimed_q;
		pos_d     = '0;
		len_d     = '0;
		err_d     = 1'b0;
		wr_en     = 1'b0;
		rd_ok     = 1'b0;
		case (req_q)
			REQ_APPEND: begin
				if (used_q >= sz) begin
					err_d = 1'b1;
				end else begin
					wr_en  = 1'b1;
					tail_d = tail_adv;
					used_d = used_q + CNT_W'(1);
				end
			end
			REQ_READ_AT: begin
				if (amount_q >= used_q) err_d = 1'b1;
				else rd_ok = 1'b1;
			end
			REQ_CLAIM: begin
				pos_d     = claim_pos;
				len_d     = claim_len;
				claimed_d = claimed_q + claim_len;
			end
			REQ_CONSUME: begin
				if (amount_q > used_q) begin
					err_d = 1'b1;
				end else begin
					used_d    = used_q - amount_q;
					claimed_d = (claimed_q > amount_q) ? claimed_q - amount_q : '0;
					if (used_q == amount_q) begin
						head_d = '0;
						tail_d = '0;
					end else begin
						head_d = head_adv;
					end
				end
			end
			REQ_TAIL_SPACE: begin
				pos_d = tail_q;
				if (tail_q > head_q || used_q == '0) len_d = sz - CNT_W'(tail_q);
				else len_d = CNT_W'(head_q) - CNT_W'(tail_q);
			end
			REQ_ADVANCE: begin
				if (amount_q > space) begin
					err_d = 1'b1;
				end else begin
					tail_d = tail_adv;
					used_d = used_q + amount_q;
				end
			end
			REQ_CLEAR: begin
				head_d    = '0;
				tail_d    = '0;
				used_d    = '0;
				claimed_d = '0;
			end
			REQ_WRITE_AHEAD: begin
				if (amount_q >= space) err_d = 1'b1;
				else wr_en = 1'b1;
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (wr_en) begin
				mem[mem_addr] <= data_q;
			end
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			data_q   <= data_byte;
			amount_q <= amount;
		end
		if (cmd.exec) begin
			pos_q <= pos_d;
			len_q <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= CNT_W'(DEPTH);
			head_q     <= '0;
			tail_q     <= '0;
			used_q     <= '0;
			claimed_q  <= '0;
			rd_ok_q    <= 1'b0;
			err_q      <= 1'b0;
		end else if (cmd.cfg_wr) begin
			buf_size_q <= cfg_data;
			head_q     <= '0;
			tail_q     <= '0;
			used_q     <= '0;
			claimed_q  <= '0;
		end else if (cmd.exec) begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			used_q    <= used_d;
			claimed_q <= claimed_d;
			rd_ok_q   <= rd_ok;
			err_q     <= err_d;
		end
	end

	assign read_byte      = rd_ok_q ? rdata_q : '0;
	assign chunk_pos      = pos_q;
	assign chunk_len      = len_q;
	assign used_count     = used_q;
	assign free_count     = space;
	assign inflight_count = claimed_q;
	assign error          = err_q;

endmodule

`default_nettype wire

// ===== hw/rtl/brbi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brbi_checker import brbi_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire logic             done,
	input  wire logic [DAT_W-1:0] read_byte,
	input  wire logic [POS_W-1:0] chunk_pos,
	input  wire logic [CNT_W-1:0] chunk_len,
	input  wire logic [CNT_W-1:0] used_count,
	input  wire logic [CNT_W-1:0] inflight_count,
	input  wire logic             error
);

	// every accepted request executes in the following cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not execute");

	// execution is followed by exactly one result beat
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("no result beat after execution");

	a_done_only_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a request");

	// claimed bytes never outnumber held bytes, and held bytes never exceed DEPTH
	a_inflight_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> inflight_count <= used_count && used_count <= CNT_W'(DEPTH))
		else $error("count bookkeeping out of range");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		done && error |-> read_byte == '0 && chunk_pos == '0 && chunk_len == '0)
		else $error("refused request reported data");

endmodule

bind byte_ring_buffer_inflight_top brbi_checker u_brbi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.read_byte      (read_byte),
	.chunk_pos      (chunk_pos),
	.chunk_len      (chunk_len),
	.used_count     (used_count),
	.inflight_count (inflight_count),
	.error          (error)
);

`default_nettype wire
